// ===== hw/rtl/rrhit_pkg.sv =====
// Shared types, codes and defaults for the rounded-rectangle pointer hit test.
`timescale 1ns / 1ps

package rrhit_pkg;

    localparam int AREAS_PER_LIST = 16;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_ENTER  = 3'd1;
    localparam logic [2:0] OP_LEAVE  = 3'd2;
    localparam logic [2:0] OP_MOTION = 3'd3;
    localparam logic [2:0] OP_BUTTON = 3'd4;

    localparam logic [1:0] BUTTON_LEFT  = 2'd0;
    localparam logic [1:0] BUTTON_RIGHT = 2'd1;

    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_CLICK = 1'b1;

    typedef struct packed {
        logic [2:0]         operation;
        logic               list_select;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [15:0] area_x;
        logic signed [15:0] area_y;
        logic [14:0]        area_width;
        logic [14:0]        area_height;
        logic [13:0]        area_radius;
        logic [1:0]         button_id;
        logic               pressed;
    } cmd_t;

    typedef struct packed {
        logic       result_kind;
        logic       hit;
        logic [3:0] area_index;
        logic       list_full;
    } result_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [13:0]        r;
    } area_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic write_area;
        logic load_pos;
        logic set_surface;
        logic clr_surface;
        logic rd_en;
        logic rd_last;
        logic flush;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] operation;
        logic [1:0] button_id;
        logic       pressed;
        logic       on_surface;
        logic       s3_valid;
        logic       s3_hit;
        logic       s3_last;
    } dp_stat_t;

endpackage

// ===== hw/rtl/rounded_rect_pointer_hit_test_top.sv =====
// Top level of the rounded-rectangle pointer hit test.
`timescale 1ns / 1ps

// Channel   Ports                    Transaction taken when
// -------   ----------------------   -----------------------------------
// command   start, busy, cmd         rising edge with start high, busy low
// result    done, result             rising edge ending the cycle done is high
//
// An add passes from idle through the execute state and shows its acknowledge in the cycle after that.
// Enter, leave, motion and ignored codes pass through the execute state and give no result.
// A left or right press walks its table through the area memory read port, one
// area per cycle behind a three-stage test pipeline; an empty table reports a
// miss without a walk.
// Reset clears pointer state and both table counts; the memory needs no pass.
// The receiver cannot stall: done is high for exactly one cycle; result holds until the next result.

module rounded_rect_pointer_hit_test_top #(
    parameter int AREAS_PER_LIST = rrhit_pkg::AREAS_PER_LIST
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  rrhit_pkg::cmd_t    cmd,
    output logic               done,
    output rrhit_pkg::result_t result
);

    localparam int IW = (AREAS_PER_LIST > 1) ? $clog2(AREAS_PER_LIST) : 1;
    localparam int CW = $clog2(AREAS_PER_LIST + 1);

    rrhit_pkg::ctrl_cmd_t ctl;
    rrhit_pkg::dp_stat_t  stat;
    logic [IW-1:0]        rd_idx;
    logic [IW-1:0]        hit_idx;
    logic [CW-1:0]        add_count;
    logic [CW-1:0]        click_count;

    // Sequence each transaction and hold the result register
    rrhit_ctrl #(
        .AREAS_PER_LIST (AREAS_PER_LIST),
        .IW             (IW),
        .CW             (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .done        (done),
        .result      (result),
        .ctl         (ctl),
        .rd_idx      (rd_idx),
        .stat        (stat),
        .add_count   (add_count),
        .click_count (click_count),
        .hit_idx     (hit_idx)
    );

    // Hold pointer state, both area tables and the hit-test pipeline
    rrhit_dp #(
        .AREAS_PER_LIST (AREAS_PER_LIST),
        .IW             (IW),
        .CW             (CW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_in      (cmd),
        .ctl         (ctl),
        .rd_idx      (rd_idx),
        .stat        (stat),
        .add_count   (add_count),
        .click_count (click_count),
        .hit_idx     (hit_idx)
    );

`ifndef NO_ASSERTIONS
    // An accepted transaction always occupies the block in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

    // A result only follows a cycle of work on a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
    else $error("result appeared without a transaction in progress");

    // A refused add reports index zero and is never a click
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.list_full) |->
            (result.result_kind == rrhit_pkg::KIND_ACK) && (result.area_index == 4'd0))
    else $error("full flag on a malformed result");

    // Pipeline flush happens only on the hit that ends a walk
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.flush |=> (done && result.hit && !busy))
    else $error("flush without a reported hit");
`endif

endmodule

// ===== hw/rtl/rrhit_dp.sv =====
// Datapath: transaction register, pointer state, area memory and hit-test pipeline.
`timescale 1ns / 1ps

module rrhit_dp #(
    parameter int AREAS_PER_LIST = rrhit_pkg::AREAS_PER_LIST,
    parameter int IW = (AREAS_PER_LIST > 1) ? $clog2(AREAS_PER_LIST) : 1,
    parameter int CW = $clog2(AREAS_PER_LIST + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rrhit_pkg::cmd_t     cmd_in,
    input  rrhit_pkg::ctrl_cmd_t ctl,
    input  logic [IW-1:0]       rd_idx,
    output rrhit_pkg::dp_stat_t stat,
    output logic [CW-1:0]       add_count,
    output logic [CW-1:0]       click_count,
    output logic [IW-1:0]       hit_idx
);

    localparam int DEPTH = 2 * AREAS_PER_LIST;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = 19;
    localparam logic [AW-1:0] HALF = AW'(AREAS_PER_LIST);

    rrhit_pkg::cmd_t    cmd_reg;
    logic               on_surface_reg;
    logic signed [23:0] cur_x_reg;
    logic signed [23:0] cur_y_reg;
    logic [CW-1:0]      left_count_reg;
    logic [CW-1:0]      right_count_reg;

    rrhit_pkg::area_t   area_mem [DEPTH];
    rrhit_pkg::area_t   new_area;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [IW-1:0]      wr_idx;

    // Stage 1: read data
    logic               s1_valid_reg;
    logic               s1_last_reg;
    logic [IW-1:0]      s1_idx_reg;
    rrhit_pkg::area_t   rd_data_reg;

    // Stage 2: box test and corner offsets
    logic               s2_valid_reg;
    logic               s2_last_reg;
    logic [IW-1:0]      s2_idx_reg;
    logic               s2_in_box_reg;
    logic signed [SW-1:0] s2_dx_reg;
    logic signed [SW-1:0] s2_dy_reg;
    logic [13:0]        s2_r_reg;

    // Stage 3: squares
    logic               s3_valid_reg;
    logic               s3_last_reg;
    logic [IW-1:0]      s3_idx_reg;
    logic               s3_in_box_reg;
    logic [2*SW-1:0]    s3_dx2_reg;
    logic [2*SW-1:0]    s3_dy2_reg;
    logic [27:0]        s3_r2_reg;

    logic signed [15:0]   px;
    logic signed [15:0]   py;
    logic signed [SW-1:0] pxs, pys, x0, y0, x1, y1, rs, lox, hix, loy, hiy, nx, ny;
    logic                 in_box;
    logic [2*SW:0]        sq_sum;

    // Truncate the 16.8 position toward zero
    assign px = cur_x_reg[23:8] + 16'(cur_x_reg[23] & (|cur_x_reg[7:0]));
    assign py = cur_y_reg[23:8] + 16'(cur_y_reg[23] & (|cur_y_reg[7:0]));

    assign add_count   = cmd_reg.list_select ? right_count_reg : left_count_reg;
    assign click_count = cmd_reg.button_id[0] ? right_count_reg : left_count_reg;
    assign wr_idx      = add_count[IW-1:0];
    assign wr_addr     = cmd_reg.list_select ? HALF + AW'(wr_idx) : AW'(wr_idx);
    assign rd_addr     = cmd_reg.button_id[0] ? HALF + AW'(rd_idx) : AW'(rd_idx);

    always_comb
    begin
        new_area.x = cmd_reg.area_x;
        new_area.y = cmd_reg.area_y;
        new_area.w = cmd_reg.area_width;
        new_area.h = cmd_reg.area_height;
        new_area.r = cmd_reg.area_radius;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_surface_reg  <= 1'b0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            left_count_reg  <= '0;
            right_count_reg <= '0;
        end
        else
        begin
            if (ctl.set_surface)
            begin
                on_surface_reg <= 1'b1;
            end
            else if (ctl.clr_surface)
            begin
                on_surface_reg <= 1'b0;
            end
            if (ctl.load_pos)
            begin
                cur_x_reg <= cmd_reg.pos_x;
                cur_y_reg <= cmd_reg.pos_y;
            end
            if (ctl.write_area)
            begin
                if (cmd_reg.list_select)
                begin
                    right_count_reg <= right_count_reg + CW'(1);
                end
                else
                begin
                    left_count_reg <= left_count_reg + CW'(1);
                end
            end
        end
    end

    // Area memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.write_area)
        begin
            area_mem[wr_addr] <= new_area;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= area_mem[rd_addr];
        end
    end

    // Box test and clamp to the corner-circle centers
    always_comb
    begin
        pxs = SW'(px);
        pys = SW'(py);
        x0  = SW'(rd_data_reg.x);
        y0  = SW'(rd_data_reg.y);
        x1  = x0 + $signed(SW'(rd_data_reg.w));
        y1  = y0 + $signed(SW'(rd_data_reg.h));
        rs  = $signed(SW'(rd_data_reg.r));
        lox = x0 + rs;
        hix = x1 - rs;
        loy = y0 + rs;
        hiy = y1 - rs;
        in_box = (pxs >= x0) && (pxs <= x1) && (pys >= y0) && (pys <= y1);
        if (pxs < lox)
        begin
            nx = lox;
        end
        else if (pxs > hix)
        begin
            nx = hix;
        end
        else
        begin
            nx = pxs;
        end
        if (pys < loy)
        begin
            ny = loy;
        end
        else if (pys > hiy)
        begin
            ny = hiy;
        end
        else
        begin
            ny = pys;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (ctl.flush)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctl.rd_en;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg   <= ctl.rd_last;
        s1_idx_reg    <= rd_idx;
        s2_last_reg   <= s1_last_reg;
        s2_idx_reg    <= s1_idx_reg;
        s2_in_box_reg <= in_box;
        s2_dx_reg     <= pxs - nx;
        s2_dy_reg     <= pys - ny;
        s2_r_reg      <= rd_data_reg.r;
        s3_last_reg   <= s2_last_reg;
        s3_idx_reg    <= s2_idx_reg;
        s3_in_box_reg <= s2_in_box_reg;
        s3_dx2_reg    <= (2*SW)'(s2_dx_reg * s2_dx_reg);
        s3_dy2_reg    <= (2*SW)'(s2_dy_reg * s2_dy_reg);
        s3_r2_reg     <= 28'(s2_r_reg * s2_r_reg);
    end

    assign sq_sum = {1'b0, s3_dx2_reg} + {1'b0, s3_dy2_reg};

    always_comb
    begin
        stat.operation  = cmd_reg.operation;
        stat.button_id  = cmd_reg.button_id;
        stat.pressed    = cmd_reg.pressed;
        stat.on_surface = on_surface_reg;
        stat.s3_valid   = s3_valid_reg;
        stat.s3_hit     = s3_in_box_reg && (sq_sum <= (2*SW+1)'(s3_r2_reg));
        stat.s3_last    = s3_last_reg;
    end

    assign hit_idx = s3_idx_reg;

endmodule

// ===== hw/rtl/rrhit_ctrl.sv =====
// Controller: transaction sequencing, table walk and result register.
`timescale 1ns / 1ps

module rrhit_ctrl #(
    parameter int AREAS_PER_LIST = rrhit_pkg::AREAS_PER_LIST,
    parameter int IW = (AREAS_PER_LIST > 1) ? $clog2(AREAS_PER_LIST) : 1,
    parameter int CW = $clog2(AREAS_PER_LIST + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    output rrhit_pkg::result_t   result,
    output rrhit_pkg::ctrl_cmd_t ctl,
    output logic [IW-1:0]        rd_idx,
    input  rrhit_pkg::dp_stat_t  stat,
    input  logic [CW-1:0]        add_count,
    input  logic [CW-1:0]        click_count,
    input  logic [IW-1:0]        hit_idx
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEARCH
    } state_t;

    state_t             state_reg, state_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic               issue_done_reg, issue_done_next;
    logic               done_reg, done_next;
    rrhit_pkg::result_t result_reg, result_next;
    logic               is_full;
    logic               is_click;

    assign is_full  = (add_count == CW'(AREAS_PER_LIST));
    assign is_click = stat.pressed &&
                      ((stat.button_id == rrhit_pkg::BUTTON_LEFT) ||
                       (stat.button_id == rrhit_pkg::BUTTON_RIGHT));

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        issue_done_next = issue_done_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        ctl             = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (stat.operation)
                    rrhit_pkg::OP_ADD:
                    begin
                        done_next               = 1'b1;
                        result_next.result_kind = rrhit_pkg::KIND_ACK;
                        result_next.hit         = 1'b0;
                        if (is_full)
                        begin
                            result_next.area_index = '0;
                            result_next.list_full  = 1'b1;
                        end
                        else
                        begin
                            result_next.area_index = 4'(add_count);
                            result_next.list_full  = 1'b0;
                            ctl.write_area         = 1'b1;
                        end
                    end
                    rrhit_pkg::OP_ENTER:
                    begin
                        ctl.load_pos    = 1'b1;
                        ctl.set_surface = 1'b1;
                    end
                    rrhit_pkg::OP_LEAVE:
                    begin
                        ctl.clr_surface = 1'b1;
                    end
                    rrhit_pkg::OP_MOTION:
                    begin
                        ctl.load_pos = stat.on_surface;
                    end
                    rrhit_pkg::OP_BUTTON:
                    begin
                        if (is_click)
                        begin
                            if (click_count == '0)
                            begin
                                done_next               = 1'b1;
                                result_next.result_kind = rrhit_pkg::KIND_CLICK;
                                result_next.hit         = 1'b0;
                                result_next.area_index  = '0;
                                result_next.list_full   = 1'b0;
                            end
                            else
                            begin
                                // Walk from the newest area down to the oldest
                                idx_next        = IW'(click_count - CW'(1));
                                issue_done_next = 1'b0;
                                state_next      = ST_SEARCH;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SEARCH:
            begin
                if (stat.s3_valid && stat.s3_hit)
                begin
                    // First hit in walk order wins; drop the rest in flight
                    done_next               = 1'b1;
                    result_next.result_kind = rrhit_pkg::KIND_CLICK;
                    result_next.hit         = 1'b1;
                    result_next.area_index  = 4'(hit_idx);
                    result_next.list_full   = 1'b0;
                    ctl.flush               = 1'b1;
                    state_next              = ST_IDLE;
                end
                else if (stat.s3_valid && stat.s3_last)
                begin
                    done_next               = 1'b1;
                    result_next.result_kind = rrhit_pkg::KIND_CLICK;
                    result_next.hit         = 1'b0;
                    result_next.area_index  = '0;
                    result_next.list_full   = 1'b0;
                    state_next              = ST_IDLE;
                end
                else if (!issue_done_reg)
                begin
                    ctl.rd_en   = 1'b1;
                    ctl.rd_last = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg - IW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            issue_done_reg <= 1'b1;
            done_reg       <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            issue_done_reg <= issue_done_next;
            done_reg       <= done_next;
            result_reg     <= result_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign rd_idx = idx_reg;

endmodule
